// File: design/mmfc_pkg.sv
// ----------------------------------------------------------------------------
// mmfc_pkg
// Shared types and constants of the multi-mode frame check validator:
// check mode codes, register indexes, item structs and reset values.
// ----------------------------------------------------------------------------
package mmfc_pkg;

    // Check mode codes (codes 6 and 7 are unused and fold nothing)
    localparam logic [2:0] MODE_ADD      = 3'd0;
    localparam logic [2:0] MODE_XOR      = 3'd1;
    localparam logic [2:0] MODE_FLETCHER = 3'd2;
    localparam logic [2:0] MODE_CRC8     = 3'd3;
    localparam logic [2:0] MODE_CRC16    = 3'd4;
    localparam logic [2:0] MODE_CRC32    = 3'd5;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLY     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_XOR_OUT  = 8'd3;

    // Register reset values
    localparam logic [2:0]  RST_MODE    = MODE_CRC32;
    localparam logic [31:0] RST_POLY    = 32'h04C1_1DB7;
    localparam logic [31:0] RST_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_XOR_OUT = 32'hFFFF_FFFF;

    // Fletcher modulus
    localparam logic [8:0] FLETCHER_MOD = 9'd255;

    // Input item
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        last_item;
        logic [31:0] expected;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic        match;
        logic [31:0] computed;
    } t_out_item;

    // Configuration register set
    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] poly;
        logic [31:0] init_value;
        logic [31:0] xor_out;
    } t_cfg;

    // Running check state
    typedef struct packed {
        logic [31:0] accumulator;
        logic [7:0]  second_sum;
    } t_fold_state;

endpackage

// File: design/mmfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// mmfc_cfg_regs
// Configuration register file: mode, polynomial, start value and final XOR.
// Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module mmfc_cfg_regs
    import mmfc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [CFG_IDX_W-1:0] i_wr_index,
    input  logic [31:0]          i_wr_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_index)
                REG_MODE:    n_cfg.mode       = i_wr_data[2:0];
                REG_POLY:    n_cfg.poly       = i_wr_data;
                REG_INIT:    n_cfg.init_value = i_wr_data;
                REG_XOR_OUT: n_cfg.xor_out    = i_wr_data;
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= RST_MODE;
            r_cfg.poly       <= RST_POLY;
            r_cfg.init_value <= RST_INIT;
            r_cfg.xor_out    <= RST_XOR_OUT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/mmfc_fold_unit.sv
// ----------------------------------------------------------------------------
// mmfc_fold_unit
// Combinational fold of one item into the running check state, plus the
// final check value and match flag for the closing item of a frame.
// ----------------------------------------------------------------------------
module mmfc_fold_unit
    import mmfc_pkg::*;
(
    input  t_cfg        i_cfg,
    input  t_in_item    i_item,
    input  logic        i_frame_open,
    input  t_fold_state i_state,
    output t_fold_state o_state,
    output t_out_item   o_result
);

    // MSB-first CRC over one byte; eight bit steps unrolled into an XOR net
    function automatic logic [31:0] crc_fold(
        input logic [31:0] acc,
        input logic [7:0]  d,
        input logic [31:0] p_in,
        input logic [2:0]  m
    );
        logic [31:0] mask;
        logic [31:0] top;
        logic [31:0] dsh;
        logic [31:0] p;
        logic [31:0] c;
        case (m)
            MODE_CRC8: begin
                mask = 32'h0000_00FF;
                top  = 32'h0000_0080;
                dsh  = {24'd0, d};
            end
            MODE_CRC16: begin
                mask = 32'h0000_FFFF;
                top  = 32'h0000_8000;
                dsh  = {16'd0, d, 8'd0};
            end
            default: begin
                mask = 32'hFFFF_FFFF;
                top  = 32'h8000_0000;
                dsh  = {d, 24'd0};
            end
        endcase
        p = p_in & mask;
        c = (acc ^ dsh) & mask;
        for (int k = 0; k < 8; k++) begin
            if ((c & top) != 32'd0)
                c = ((c << 1) ^ p) & mask;
            else
                c = (c << 1) & mask;
        end
        return c;
    endfunction

    t_fold_state s_base;
    t_fold_state s_next;
    logic [8:0]  s1_sum;
    logic [7:0]  s1;
    logic [8:0]  s2_sum;
    logic [7:0]  s2;
    logic [31:0] check_mask;
    logic [31:0] comp;
    logic        comp_ok;

    // Start values on the first item of a frame
    always_comb begin
        if (!i_frame_open) begin
            s_base.accumulator = i_cfg.init_value;
            s_base.second_sum  = i_cfg.init_value[15:8];
        end else begin
            s_base = i_state;
        end
    end

    // Fletcher sums mod 255; sum1 input can reach 510
    always_comb begin
        s1_sum = {1'b0, s_base.accumulator[7:0]} + {1'b0, i_item.data_byte};
        if (s1_sum >= {FLETCHER_MOD[7:0], 1'b0})
            s1 = 8'd0;
        else if (s1_sum >= FLETCHER_MOD)
            s1 = 8'(s1_sum - FLETCHER_MOD);
        else
            s1 = s1_sum[7:0];
        s2_sum = {1'b0, s_base.second_sum} + {1'b0, s1};
        if (s2_sum >= FLETCHER_MOD)
            s2 = 8'(s2_sum - FLETCHER_MOD);
        else
            s2 = s2_sum[7:0];
    end

    // Fold the byte by mode
    always_comb begin
        s_next = s_base;
        if (i_item.byte_valid) begin
            case (i_cfg.mode)
                MODE_ADD:
                    s_next.accumulator = s_base.accumulator + {24'd0, i_item.data_byte};
                MODE_XOR:
                    s_next.accumulator = s_base.accumulator ^ {24'd0, i_item.data_byte};
                MODE_FLETCHER: begin
                    s_next.accumulator = {24'd0, s1};
                    s_next.second_sum  = s2;
                end
                MODE_CRC8, MODE_CRC16, MODE_CRC32:
                    s_next.accumulator = crc_fold(s_base.accumulator, i_item.data_byte,
                                                  i_cfg.poly, i_cfg.mode);
                default:
                    s_next = s_base;
            endcase
        end
    end

    // Final check value and width by mode
    always_comb begin
        comp_ok = 1'b1;
        case (i_cfg.mode)
            MODE_ADD, MODE_XOR: begin
                check_mask = 32'h0000_00FF;
                comp       = s_next.accumulator & check_mask;
            end
            MODE_FLETCHER: begin
                check_mask = 32'h0000_FFFF;
                comp       = {16'd0, s_next.second_sum, s_next.accumulator[7:0]};
            end
            MODE_CRC8: begin
                check_mask = 32'h0000_00FF;
                comp       = (s_next.accumulator ^ i_cfg.xor_out) & check_mask;
            end
            MODE_CRC16: begin
                check_mask = 32'h0000_FFFF;
                comp       = (s_next.accumulator ^ i_cfg.xor_out) & check_mask;
            end
            MODE_CRC32: begin
                check_mask = 32'hFFFF_FFFF;
                comp       = s_next.accumulator ^ i_cfg.xor_out;
            end
            default: begin
                check_mask = 32'd0;
                comp       = 32'd0;
                comp_ok    = 1'b0;
            end
        endcase
    end

    assign o_state           = s_next;
    assign o_result.computed = comp;
    assign o_result.match    = comp_ok && (comp == (i_item.expected & check_mask));

endmodule

// File: design/multi_mode_frame_check_validator.sv
// ----------------------------------------------------------------------------
// multi_mode_frame_check_validator
// Frame integrity checker over a byte stream: additive, XOR, Fletcher-16 and
// MSB-first CRC-8/16/32, with one result per frame.
// ----------------------------------------------------------------------------
// One item per clock while no waiting result holds back a frame end. An
// accepted item sits in the input register while the fold unit (eight CRC
// bit steps unrolled into one XOR network, or the mod-255 adds for Fletcher)
// works on it; when it advances the check state updates and, for the last
// item of a frame, the result register loads and holds the result until it
// is taken. A result waiting on the output only holds up the input register
// when the item it holds is also a frame end; other items keep flowing.
// Configuration writes are accepted in every cycle and should be made while
// no item is in flight.
module multi_mode_frame_check_validator
    import mmfc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item input
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_cfg        cfg;
    t_fold_state fold_state;
    t_out_item   fold_result;

    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_frame_open;
    t_fold_state r_state;
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic        advance;
    logic        in_take;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    mmfc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Fold datapath
    mmfc_fold_unit u_fold_unit (
        .i_cfg        (cfg),
        .i_item       (r_in_item),
        .i_frame_open (r_frame_open),
        .i_state      (r_state),
        .o_state      (fold_state),
        .o_result     (fold_result)
    );

    // Handshake: a frame end needs a free result slot
    assign advance    = r_in_valid &&
                        (!r_in_item.last_item || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    // Check state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_state      <= '0;
        end else if (advance) begin
            r_frame_open <= !r_in_item.last_item;
            r_state      <= fold_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_item.last_item) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_item.last_item) begin
            r_out_item <= fold_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef NO_ASSERTIONS
    // A result only appears after a frame-end item left the input register
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid && r_in_item.last_item))
        else $error("result without frame end");

    // Frame end closes the frame
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_item.last_item) |=> !r_frame_open)
        else $error("frame still open after frame end");

    // Any other item leaves the frame open
    a_mid_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_in_item.last_item) |=> r_frame_open)
        else $error("frame not open after mid-frame item");

    // Pending result is never overwritten while stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(advance && r_in_item.last_item))
        else $error("pending result overwritten");
`endif

endmodule
